>>> src/trd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_pkg
// Shared widths, opcodes and the multiply-accumulate command type of the
// triangle rasterizer with depth test.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int OP_W          = 2;
    localparam int COORD_W       = 11;
    localparam int Z_W           = 16;
    localparam int COLOR_W       = 24;
    localparam int ADDR_IN_W     = 14;
    localparam int COUNT_W       = 15;
    localparam int SUBPIXEL_BITS = 4;
    localparam int SUB_HALF      = (1 << SUBPIXEL_BITS) >> 1;

    // pixel coordinate, wide enough for the largest screen
    localparam int PX_W      = 11;
    localparam int EDGE_W    = 32;
    localparam int MUL_B_W   = 17;
    localparam int ACC_W     = 50;
    localparam int AREA_W    = 25;
    // quotient magnitude never exceeds the largest vertex depth
    localparam int QUOT_BITS = 17;
    localparam int QUOT_W    = QUOT_BITS + 1;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [COLOR_W-1:0] BG_RESET  = 24'h111133;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7fff;

    typedef logic [1:0] t_mac_op;
    localparam t_mac_op MAC_NOP  = 2'd0;
    localparam t_mac_op MAC_LOAD = 2'd1;
    localparam t_mac_op MAC_ADD  = 2'd2;
    localparam t_mac_op MAC_SUB  = 2'd3;

    typedef struct packed {
        t_mac_op             op;
        logic [EDGE_W-1:0]   a;
        logic [MUL_B_W-1:0]  b;
    } t_mac_cmd;

endpackage

>>> src/triangle_raster_depth_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_raster_depth_test
// Triangle rasterizer with colour and depth stores and a strict depth test.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_ready carries one operation per beat: clear, draw
// or read. Output channel o_valid/i_ready returns one result beat for each.
// o_ready is high only while the sequencer is idle; one operation at a time.
// Clear sweeps the stores, one pixel a cycle. Read fetches the colour and
// registers it. Draw first computes the area and the clipped bounding box,
// then walks each pixel of the box: the shared multiply-accumulate unit
// computes the edge weights u and v and, for pixels inside, the depth numerator,
// and the serial divider turns out the quotient bits of each depth.
// Stores hold nothing defined after reset; a clear must come first. The
// background colour register resets to 0x111133 and is written through
// i_cfg_wr_en/i_cfg_wr_data; the user must write it only while idle, which
// the block does not enforce. A stalled result stays in the output register;
// the sequencer then holds in its final state until it drains.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test import trd_pkg::*; #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128,
    parameter int DEPTH_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [OP_W-1:0]       i_opcode,
    input  logic [COORD_W-1:0]    i_vertex0_x,
    input  logic [COORD_W-1:0]    i_vertex0_y,
    input  logic signed [Z_W-1:0] i_vertex0_z,
    input  logic [COORD_W-1:0]    i_vertex1_x,
    input  logic [COORD_W-1:0]    i_vertex1_y,
    input  logic signed [Z_W-1:0] i_vertex1_z,
    input  logic [COORD_W-1:0]    i_vertex2_x,
    input  logic [COORD_W-1:0]    i_vertex2_y,
    input  logic signed [Z_W-1:0] i_vertex2_z,
    input  logic [COLOR_W-1:0]    i_fill_color,
    input  logic [ADDR_IN_W-1:0]  i_read_address,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic [COUNT_W-1:0]    o_pixels_written,
    output logic                  o_degenerate,
    input  logic                  i_cfg_wr_en,
    input  logic [COLOR_W-1:0]    i_cfg_wr_data
);

    localparam int PIX = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW  = $clog2(PIX);
    localparam logic signed [32:0] DMAX = (33'sd1 <<< (DEPTH_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] DMIN = -(33'sd1 <<< (DEPTH_BITS - 1));

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_RD0  = 5'd2;
    localparam logic [4:0] S_RD1  = 5'd3;
    localparam logic [4:0] S_AR0  = 5'd4;
    localparam logic [4:0] S_AR1  = 5'd5;
    localparam logic [4:0] S_AR2  = 5'd6;
    localparam logic [4:0] S_AR3  = 5'd7;
    localparam logic [4:0] S_U0   = 5'd8;
    localparam logic [4:0] S_U1   = 5'd9;
    localparam logic [4:0] S_U2   = 5'd10;
    localparam logic [4:0] S_U3   = 5'd11;
    localparam logic [4:0] S_V1   = 5'd12;
    localparam logic [4:0] S_V2   = 5'd13;
    localparam logic [4:0] S_V3   = 5'd14;
    localparam logic [4:0] S_W    = 5'd15;
    localparam logic [4:0] S_N1   = 5'd16;
    localparam logic [4:0] S_N2   = 5'd17;
    localparam logic [4:0] S_N3   = 5'd18;
    localparam logic [4:0] S_N4   = 5'd19;
    localparam logic [4:0] S_DIV  = 5'd20;
    localparam logic [4:0] S_WR   = 5'd21;
    localparam logic [4:0] S_OUT  = 5'd22;

    function automatic logic [PX_W-1:0] round_px(input logic [COORD_W-1:0] c);
        logic [COORD_W:0] s;
        s = (COORD_W+1)'(c) + (COORD_W+1)'(SUB_HALF);
        return PX_W'(s >> SUBPIXEL_BITS);
    endfunction

    logic [4:0]               r_state;
    logic [4:0]               n_state;
    logic [COLOR_W-1:0]       r_bg;
    logic [COORD_W-1:0]       r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [Z_W-1:0]    r_az, r_bz, r_cz;
    logic [COLOR_W-1:0]       r_fill;
    logic [AW-1:0]            r_addr;
    logic                     r_rd_ok;
    logic                     r_neg;
    logic [AREA_W-1:0]        r_area;
    logic signed [EDGE_W-1:0] r_u, r_v, r_w;
    logic [PX_W-1:0]          r_x, r_y, r_x0, r_x1, r_y1;
    logic [AW-1:0]            r_row_base;
    logic [AW-1:0]            r_clr_idx;
    logic [COUNT_W-1:0]       r_count;
    logic [COLOR_W-1:0]       r_res_color;
    logic                     r_res_degen;
    logic                     r_o_valid;
    logic [COLOR_W-1:0]       r_o_color;
    logic [COUNT_W-1:0]       r_o_count;
    logic                     r_o_degen;
    logic [COLOR_W-1:0]       r_color_q;
    logic [DEPTH_BITS-1:0]    r_depth_q;

    logic [COLOR_W-1:0]       color_mem [PIX];
    logic [DEPTH_BITS-1:0]    depth_mem [PIX];

    logic                     in_beat;
    logic                     out_load;
    logic signed [COORD_W:0]  abx, aby, acx, acy;
    logic signed [MUL_B_W-1:0] pax, pay;
    logic signed [ACC_W-1:0]  mac_acc;
    logic signed [EDGE_W-1:0] acc_lo, edge_now, w_now;
    logic                     in_tri;
    logic [PX_W-1:0]          min_x, max_x, min_y, max_y;
    logic [PX_W-1:0]          box_x0, box_x1, box_y0, box_y1;
    logic                     box_empty;
    logic [AW-1:0]            idx;
    logic                     last_x, last_y;
    logic                     div_done;
    logic signed [QUOT_W-1:0] quot;
    logic signed [32:0]       quot_x;
    logic [DEPTH_BITS-1:0]    z_sat;
    logic                     z_pass;
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic [COLOR_W-1:0]       mem_wc;
    logic [DEPTH_BITS-1:0]    mem_wd;
    t_mac_cmd                 mac_cmd;

    assign in_beat  = i_valid && o_ready;
    assign out_load = (r_state == S_OUT) && (!r_o_valid || i_ready);

    assign abx = $signed({1'b0, r_bx}) - $signed({1'b0, r_ax});
    assign aby = $signed({1'b0, r_by}) - $signed({1'b0, r_ay});
    assign acx = $signed({1'b0, r_cx}) - $signed({1'b0, r_ax});
    assign acy = $signed({1'b0, r_cy}) - $signed({1'b0, r_ay});
    assign pax = $signed(MUL_B_W'(r_ax)) - $signed(MUL_B_W'({r_x, {SUBPIXEL_BITS{1'b0}}}));
    assign pay = $signed(MUL_B_W'(r_ay)) - $signed(MUL_B_W'({r_y, {SUBPIXEL_BITS{1'b0}}}));

    assign acc_lo   = mac_acc[EDGE_W-1:0];
    assign edge_now = r_neg ? -acc_lo : acc_lo;
    assign w_now    = $signed(EDGE_W'(r_area)) - r_u - r_v;
    assign in_tri   = !r_u[EDGE_W-1] && !r_v[EDGE_W-1] && !w_now[EDGE_W-1];

    // bounding box, rounded to pixels and clipped
    always_comb begin
        min_x = round_px((r_ax < r_bx) ? ((r_ax < r_cx) ? r_ax : r_cx)
                                       : ((r_bx < r_cx) ? r_bx : r_cx));
        max_x = round_px((r_ax > r_bx) ? ((r_ax > r_cx) ? r_ax : r_cx)
                                       : ((r_bx > r_cx) ? r_bx : r_cx));
        min_y = round_px((r_ay < r_by) ? ((r_ay < r_cy) ? r_ay : r_cy)
                                       : ((r_by < r_cy) ? r_by : r_cy));
        max_y = round_px((r_ay > r_by) ? ((r_ay > r_cy) ? r_ay : r_cy)
                                       : ((r_by > r_cy) ? r_by : r_cy));
        box_x0 = min_x;
        box_y0 = min_y;
        box_x1 = (32'(max_x) > SCREEN_WIDTH - 1) ? PX_W'(SCREEN_WIDTH - 1) : max_x;
        box_y1 = (32'(max_y) > SCREEN_HEIGHT - 1) ? PX_W'(SCREEN_HEIGHT - 1) : max_y;
        box_empty = (box_x0 > box_x1) || (box_y0 > box_y1);
    end

    assign idx    = r_row_base + AW'(r_x);
    assign last_x = (r_x == r_x1);
    assign last_y = (r_y == r_y1);

    // depth saturation and strict test
    assign quot_x = 33'(quot);
    assign z_sat  = (quot_x > DMAX) ? DEPTH_BITS'(DMAX) :
                    (quot_x < DMIN) ? DEPTH_BITS'(DMIN) : DEPTH_BITS'(quot_x);
    assign z_pass = $signed(z_sat) > $signed(r_depth_q);

    // shared multiplier schedule
    always_comb begin
        mac_cmd.op = MAC_NOP;
        mac_cmd.a  = '0;
        mac_cmd.b  = '0;
        case (r_state)
            S_AR0: begin
                mac_cmd.op = MAC_LOAD;
                mac_cmd.a  = EDGE_W'(abx);
                mac_cmd.b  = MUL_B_W'(acy);
            end
            S_AR1: begin
                mac_cmd.op = MAC_SUB;
                mac_cmd.a  = EDGE_W'(acx);
                mac_cmd.b  = MUL_B_W'(aby);
            end
            S_U0: begin
                mac_cmd.op = MAC_LOAD;
                mac_cmd.a  = EDGE_W'(acx);
                mac_cmd.b  = pay;
            end
            S_U1: begin
                mac_cmd.op = MAC_SUB;
                mac_cmd.a  = EDGE_W'(acy);
                mac_cmd.b  = pax;
            end
            S_U3: begin
                mac_cmd.op = MAC_LOAD;
                mac_cmd.a  = EDGE_W'(aby);
                mac_cmd.b  = pax;
            end
            S_V1: begin
                mac_cmd.op = MAC_SUB;
                mac_cmd.a  = EDGE_W'(abx);
                mac_cmd.b  = pay;
            end
            S_W: begin
                mac_cmd.op = MAC_LOAD;
                mac_cmd.a  = r_u;
                mac_cmd.b  = MUL_B_W'(r_bz);
            end
            S_N1: begin
                mac_cmd.op = MAC_ADD;
                mac_cmd.a  = r_v;
                mac_cmd.b  = MUL_B_W'(r_cz);
            end
            S_N2: begin
                mac_cmd.op = MAC_ADD;
                mac_cmd.a  = r_w;
                mac_cmd.b  = MUL_B_W'(r_az);
            end
            default: begin
                mac_cmd.op = MAC_NOP;
            end
        endcase
    end

    trd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .o_acc   (mac_acc)
    );

    trd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_N4),
        .i_dividend (mac_acc),
        .i_divisor  (r_area),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    case (i_opcode)
                        OP_CLEAR: n_state = S_CLR;
                        OP_DRAW:  n_state = S_AR0;
                        OP_READ:  n_state = S_RD0;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_CLR:  n_state = (r_clr_idx == AW'(PIX - 1)) ? S_OUT : S_CLR;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_OUT;
            S_AR0:  n_state = S_AR1;
            S_AR1:  n_state = S_AR2;
            S_AR2:  n_state = S_AR3;
            S_AR3:  n_state = (mac_acc == '0 || box_empty) ? S_OUT : S_U0;
            S_U0:   n_state = S_U1;
            S_U1:   n_state = S_U2;
            S_U2:   n_state = S_U3;
            S_U3:   n_state = S_V1;
            S_V1:   n_state = S_V2;
            S_V2:   n_state = S_V3;
            S_V3:   n_state = S_W;
            S_W: begin
                if (in_tri) begin
                    n_state = S_N1;
                end else begin
                    n_state = (last_x && last_y) ? S_OUT : S_U0;
                end
            end
            S_N1:   n_state = S_N2;
            S_N2:   n_state = S_N3;
            S_N3:   n_state = S_N4;
            S_N4:   n_state = S_DIV;
            S_DIV:  n_state = div_done ? S_WR : S_DIV;
            S_WR:   n_state = (last_x && last_y) ? S_OUT : S_U0;
            S_OUT:  n_state = out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bg      <= BG_RESET;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_bg <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_ax        <= i_vertex0_x;
            r_ay        <= i_vertex0_y;
            r_az        <= i_vertex0_z;
            r_bx        <= i_vertex1_x;
            r_by        <= i_vertex1_y;
            r_bz        <= i_vertex1_z;
            r_cx        <= i_vertex2_x;
            r_cy        <= i_vertex2_y;
            r_cz        <= i_vertex2_z;
            r_fill      <= i_fill_color;
            r_addr      <= AW'(i_read_address);
            r_rd_ok     <= 32'(i_read_address) < PIX;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_res_color <= '0;
            r_res_degen <= 1'b0;
        end
        case (r_state)
            S_CLR: r_clr_idx <= r_clr_idx + AW'(1);
            S_RD1: r_res_color <= r_rd_ok ? r_color_q : '0;
            S_AR3: begin
                r_res_degen <= (mac_acc == '0);
                r_neg       <= mac_acc[ACC_W-1];
                r_area      <= AREA_W'(mac_acc[ACC_W-1] ? -mac_acc : mac_acc);
                r_x         <= box_x0;
                r_y         <= box_y0;
                r_x0        <= box_x0;
                r_x1        <= box_x1;
                r_y1        <= box_y1;
                r_row_base  <= AW'(32'(box_y0) * SCREEN_WIDTH);
            end
            S_U3: r_u <= edge_now;
            S_V3: r_v <= edge_now;
            default: begin
            end
        endcase
        if (r_state == S_W) begin
            r_w <= w_now;
        end
        if (r_state == S_WR && z_pass && r_count != COUNT_MAX) begin
            r_count <= r_count + COUNT_W'(1);
        end
        // pixel walk, row by row
        if ((r_state == S_W && !in_tri) || r_state == S_WR) begin
            if (last_x) begin
                r_x        <= r_x0;
                r_y        <= r_y + PX_W'(1);
                r_row_base <= r_row_base + AW'(SCREEN_WIDTH);
            end else begin
                r_x <= r_x + PX_W'(1);
            end
        end
        if (out_load) begin
            r_o_color <= r_res_color;
            r_o_count <= r_count;
            r_o_degen <= r_res_degen;
        end
    end

    // store write port, shared by clear sweep and depth-test pass
    always_comb begin
        mem_we = 1'b0;
        mem_wa = idx;
        mem_wc = r_fill;
        mem_wd = z_sat;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = r_clr_idx;
            mem_wc = r_bg;
            mem_wd = DEPTH_BITS'(DMIN);
        end else if (r_state == S_WR && z_pass) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            color_mem[mem_wa] <= mem_wc;
        end
        if (r_state == S_RD0) begin
            r_color_q <= color_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            depth_mem[mem_wa] <= mem_wd;
        end
        if (r_state == S_W) begin
            r_depth_q <= depth_mem[idx];
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_pixel_color    = r_o_color;
    assign o_pixels_written = r_o_count;
    assign o_degenerate     = r_o_degen;

endmodule

>>> src/trd_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_mac
// Shared signed multiply-accumulate unit, product registered before the add.
// ----------------------------------------------------------------------------
module trd_mac import trd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_cmd                i_cmd,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [EDGE_W+MUL_B_W-1:0] r_prod;
    t_mac_op                          r_op;
    logic signed [ACC_W-1:0]          r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= MAC_NOP;
        end else begin
            r_op <= i_cmd.op;
        end
        r_prod <= $signed(i_cmd.a) * $signed(i_cmd.b);
        case (r_op)
            MAC_LOAD: r_acc <= ACC_W'(r_prod);
            MAC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
            MAC_SUB:  r_acc <= r_acc - ACC_W'(r_prod);
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

>>> src/trd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_div
// Serial restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module trd_div import trd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [ACC_W-1:0]  i_dividend,
    input  logic [AREA_W-1:0]        i_divisor,
    output logic                     o_done,
    output logic signed [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_BITS + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [AREA_W-1:0]    r_rem;
    logic [AREA_W-1:0]    r_dsr;
    logic [QUOT_BITS-1:0] r_low;
    logic [QUOT_BITS-1:0] r_q;
    logic                 r_neg;
    logic [ACC_W-1:0]     mag;
    logic [AREA_W:0]      trial;
    logic                 ge;

    assign mag   = i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
    assign trial = {r_rem, r_low[QUOT_BITS-1]};
    assign ge    = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            // upper part is below the divisor since the quotient fits QUOT_BITS
            r_rem <= mag[QUOT_BITS+AREA_W-1:QUOT_BITS];
            r_low <= mag[QUOT_BITS-1:0];
            r_dsr <= i_divisor;
            r_neg <= i_dividend[ACC_W-1];
            r_cnt <= CNT_W'(QUOT_BITS);
        end else if (r_busy) begin
            r_rem <= ge ? AREA_W'(trial - {1'b0, r_dsr}) : trial[AREA_W-1:0];
            r_low <= r_low << 1;
            r_q   <= {r_q[QUOT_BITS-2:0], ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

>>> src/trd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_checker
// Port-level checks for the triangle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module trd_checker import trd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [COLOR_W-1:0] o_pixel_color,
    input logic [COUNT_W-1:0] o_pixels_written,
    input logic               o_degenerate
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_color)
            && $stable(o_pixels_written) && $stable(o_degenerate))
        else $error("result beat changed while stalled");

    // one operation at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an accepted beat");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_pixels_written == '0 && o_pixel_color == '0)
        else $error("degenerate draw reported pixels or colour");

    a_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pixel_color != '0 |-> o_pixels_written == '0 && !o_degenerate)
        else $error("read result mixed with draw fields");

endmodule

bind triangle_raster_depth_test trd_checker u_trd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_pixel_color    (o_pixel_color),
    .o_pixels_written (o_pixels_written),
    .o_degenerate     (o_degenerate)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle rasterizer with depth test.
// Clears, triangles, reads and unused opcodes go in over valid/ready
// while a scoreboard with its own copy of the colour and depth stores works
// out every result beat. Both sides idle at random in several phases, and
// the background colour is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
    import trd_pkg::*;

    localparam int SCR_W = 128;
    localparam int SCR_H = 128;
    localparam int NPIX = SCR_W * SCR_H;
    localparam int DEPTH_LO = -32768;
    localparam int DEPTH_HI = 32767;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_PER_PHASE = 290;

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [COORD_W-1:0]    vx [3];
        logic [COORD_W-1:0]    vy [3];
        logic signed [Z_W-1:0] vz [3];
        logic [COLOR_W-1:0]    color;
        logic [ADDR_IN_W-1:0]  addr;
    } t_raster_op;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [COUNT_W-1:0] written;
        logic               degen;
    } t_raster_result;

    class raster_scoreboard;
        logic [COLOR_W-1:0] bg_color;
        logic [COLOR_W-1:0] color_mem [NPIX];
        int                 depth_mem [NPIX];
        t_raster_result     pending [$];
        int mismatches;
        int n_clear, n_draw, n_read, n_degen, n_pix;

        function new();
            bg_color = BG_RESET;
            mismatches = 0;
            n_clear = 0; n_draw = 0; n_read = 0; n_degen = 0; n_pix = 0;
        endfunction

        function void note_op(t_raster_op t);
            t_raster_result r;
            longint ax, ay, bx, by, cx, cy, abx, aby, acx, acy, area, sgn;
            longint x0, x1, y0, y1, pax, pay, u, v, w, z;
            int cnt;
            r = '{default: '0};
            case (t.op)
                OP_CLEAR: begin
                    n_clear++;
                    for (int i = 0; i < NPIX; i++) begin
                        color_mem[i] = bg_color;
                        depth_mem[i] = DEPTH_LO;
                    end
                end
                OP_READ: begin
                    n_read++;
                    r.color = color_mem[t.addr];
                end
                OP_DRAW: begin
                    n_draw++;
                    ax = t.vx[0]; ay = t.vy[0];
                    bx = t.vx[1]; by = t.vy[1];
                    cx = t.vx[2]; cy = t.vy[2];
                    abx = bx - ax; aby = by - ay; acx = cx - ax; acy = cy - ay;
                    area = abx * acy - acx * aby;
                    cnt = 0;
                    if (area == 0) begin
                        r.degen = 1'b1;
                        n_degen++;
                    end else begin
                        sgn = (area < 0) ? -1 : 1;
                        area = area * sgn;
                        x0 = (min3(ax, bx, cx) + SUB_HALF) >>> SUBPIXEL_BITS;
                        x1 = (max3(ax, bx, cx) + SUB_HALF) >>> SUBPIXEL_BITS;
                        y0 = (min3(ay, by, cy) + SUB_HALF) >>> SUBPIXEL_BITS;
                        y1 = (max3(ay, by, cy) + SUB_HALF) >>> SUBPIXEL_BITS;
                        if (x1 > SCR_W - 1) x1 = SCR_W - 1;
                        if (y1 > SCR_H - 1) y1 = SCR_H - 1;
                        for (longint y = y0; y <= y1; y++) begin
                            for (longint x = x0; x <= x1; x++) begin
                                pax = ax - (x << SUBPIXEL_BITS);
                                pay = ay - (y << SUBPIXEL_BITS);
                                u = (acx * pay - acy * pax) * sgn;
                                v = (aby * pax - abx * pay) * sgn;
                                w = area - u - v;
                                if (u >= 0 && v >= 0 && w >= 0) begin
                                    // signed division truncates toward zero
                                    z = (longint'(t.vz[0]) * w + longint'(t.vz[1]) * u
                                         + longint'(t.vz[2]) * v) / area;
                                    if (z < DEPTH_LO) z = DEPTH_LO;
                                    if (z > DEPTH_HI) z = DEPTH_HI;
                                    if (z > depth_mem[y * SCR_W + x]) begin
                                        depth_mem[y * SCR_W + x] = int'(z);
                                        color_mem[y * SCR_W + x] = t.color;
                                        if (cnt < COUNT_MAX) cnt++;
                                    end
                                end
                            end
                        end
                    end
                    r.written = cnt[COUNT_W-1:0];
                    n_pix += cnt;
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function longint min3(longint a, longint b, longint c);
            longint m;
            m = (a < b) ? a : b;
            return (m < c) ? m : c;
        endfunction

        function longint max3(longint a, longint b, longint c);
            longint m;
            m = (a > b) ? a : b;
            return (m > c) ? m : c;
        endfunction

        function void check_result(t_raster_result got);
            t_raster_result exp_r;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: result beat with nothing outstanding: color %06h cnt %0d deg %0b",
                             got.color, got.written, got.degen);
                return;
            end
            exp_r = pending.pop_front();
            if (got.color !== exp_r.color || got.written !== exp_r.written
                    || got.degen !== exp_r.degen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("error: color %06h/%06h cnt %0d/%0d deg %0b/%0b (exp/got)",
                             exp_r.color, got.color, exp_r.written, got.written,
                             exp_r.degen, got.degen);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [OP_W-1:0]       i_opcode;
    logic [COORD_W-1:0]    i_vertex0_x, i_vertex0_y, i_vertex1_x, i_vertex1_y;
    logic [COORD_W-1:0]    i_vertex2_x, i_vertex2_y;
    logic signed [Z_W-1:0] i_vertex0_z, i_vertex1_z, i_vertex2_z;
    logic [COLOR_W-1:0]    i_fill_color;
    logic [ADDR_IN_W-1:0]  i_read_address;
    logic                  o_valid;
    logic                  i_ready;
    logic [COLOR_W-1:0]    o_pixel_color;
    logic [COUNT_W-1:0]    o_pixels_written;
    logic                  o_degenerate;
    logic                  i_cfg_wr_en;
    logic [COLOR_W-1:0]    i_cfg_wr_data;

    raster_scoreboard sb;
    int  tx_idle_pct;
    int  rx_stall_pct;
    int  cycles;
    logic [ADDR_IN_W-1:0] last_hit_addr;

    triangle_raster_depth_test #(
        .SCREEN_WIDTH (SCR_W),
        .SCREEN_HEIGHT(SCR_H),
        .DEPTH_BITS   (16)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_opcode        (i_opcode),
        .i_vertex0_x     (i_vertex0_x),
        .i_vertex0_y     (i_vertex0_y),
        .i_vertex0_z     (i_vertex0_z),
        .i_vertex1_x     (i_vertex1_x),
        .i_vertex1_y     (i_vertex1_y),
        .i_vertex1_z     (i_vertex1_z),
        .i_vertex2_x     (i_vertex2_x),
        .i_vertex2_y     (i_vertex2_y),
        .i_vertex2_z     (i_vertex2_z),
        .i_fill_color    (i_fill_color),
        .i_read_address  (i_read_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_color   (o_pixel_color),
        .o_pixels_written(o_pixels_written),
        .o_degenerate    (o_degenerate),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side: check on the old sampled values, then pick the next ready
    initial begin
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result('{o_pixel_color, o_pixels_written, o_degenerate});
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_op(t_raster_op t);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= t.op;
        i_vertex0_x    <= t.vx[0]; i_vertex0_y <= t.vy[0]; i_vertex0_z <= t.vz[0];
        i_vertex1_x    <= t.vx[1]; i_vertex1_y <= t.vy[1]; i_vertex1_z <= t.vz[1];
        i_vertex2_x    <= t.vx[2]; i_vertex2_y <= t.vy[2]; i_vertex2_z <= t.vz[2];
        i_fill_color   <= t.color;
        i_read_address <= t.addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_op(t);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || !o_ready) @(posedge i_clk);
    endtask

    task automatic write_background(logic [COLOR_W-1:0] c);
        drain();
        repeat (20) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= c;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.bg_color = c;
    endtask

    function automatic t_raster_op simple_op(logic [OP_W-1:0] op, int a);
        t_raster_op t;
        t = '{op: op, vx: '{'0, '0, '0}, vy: '{'0, '0, '0}, vz: '{'0, '0, '0},
              color: '0, addr: ADDR_IN_W'(a)};
        return t;
    endfunction

    function automatic t_raster_op tri_op(int x0, int y0, int x1, int y1, int x2, int y2,
                                          int z0, int z1, int z2, logic [COLOR_W-1:0] c);
        t_raster_op t;
        t = simple_op(OP_DRAW, 0);
        t.vx = '{COORD_W'(x0), COORD_W'(x1), COORD_W'(x2)};
        t.vy = '{COORD_W'(y0), COORD_W'(y1), COORD_W'(y2)};
        t.vz = '{Z_W'(z0), Z_W'(z1), Z_W'(z2)};
        t.color = c;
        return t;
    endfunction

    function automatic int clamp_coord(int c);
        return (c < 0) ? 0 : (c > 2047) ? 2047 : c;
    endfunction

    // small triangle anywhere on the coordinate range, at most about 4x4 pixels
    function automatic t_raster_op random_tri();
        t_raster_op t;
        int bx, by;
        bx = $urandom_range(2047);
        by = $urandom_range(2047);
        t = simple_op(OP_DRAW, 0);
        for (int k = 0; k < 3; k++) begin
            t.vx[k] = COORD_W'(clamp_coord(bx + int'($urandom_range(48)) - 24));
            t.vy[k] = COORD_W'(clamp_coord(by + int'($urandom_range(48)) - 24));
            t.vz[k] = Z_W'(int'($urandom_range(32768)) - 16384);
        end
        // collinear now and then
        if ($urandom_range(19) == 0) begin
            t.vx[2] = t.vx[0];
            t.vx[1] = t.vx[0];
        end
        t.color = COLOR_W'($urandom_range(24'hffffff));
        return t;
    endfunction

    function automatic t_raster_op random_op();
        t_raster_op t;
        int r;
        r = $urandom_range(99);
        if (r < 1) begin
            t = simple_op(OP_CLEAR, 0);
        end else if (r < 55) begin
            t = random_tri();
            last_hit_addr = ADDR_IN_W'(((t.vy[0] + SUB_HALF) >> SUBPIXEL_BITS) % SCR_H * SCR_W
                            + ((t.vx[0] + SUB_HALF) >> SUBPIXEL_BITS) % SCR_W);
        end else if (r < 97) begin
            t = simple_op(OP_READ, $urandom_range(1) ? int'(last_hit_addr)
                                                     : int'($urandom_range(NPIX - 1)));
        end else begin
            t = random_tri();
            t.op = OP_UNUSED;
            t.addr = ADDR_IN_W'($urandom_range(NPIX - 1));
        end
        return t;
    endfunction

    initial begin
        logic [COLOR_W-1:0] bg_values [4];
        int tx_pcts [4];
        int rx_pcts [4];
        sb = new();
        cycles = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        last_hit_addr = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_CLEAR;
        {i_vertex0_x, i_vertex0_y, i_vertex1_x, i_vertex1_y, i_vertex2_x, i_vertex2_y} = '0;
        {i_vertex0_z, i_vertex1_z, i_vertex2_z} = '0;
        i_fill_color = '0;
        i_read_address = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        bg_values = '{24'h000000, 24'hffffff, COLOR_W'($urandom_range(24'hffffff)), BG_RESET};
        tx_pcts = '{0, 65, 0, 21};
        rx_pcts = '{0, 0, 65, 21};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clear with the reset background first, nothing is defined before it
        send_op(simple_op(OP_CLEAR, 0));
        send_op(simple_op(OP_READ, 0));
        send_op(simple_op(OP_READ, NPIX - 1));
        send_op(tri_op(0, 0, 40, 0, 0, 40, 16384, 16384, 16384, 24'hffffff));
        // same triangle at equal depth: strict test writes nothing
        send_op(tri_op(0, 0, 40, 0, 0, 40, 16384, 16384, 16384, 24'h000000));
        send_op(tri_op(0, 40, 40, 0, 0, 0, -16384, 0, 16384, 24'h000000));
        send_op(simple_op(OP_READ, 0));
        send_op(simple_op(OP_READ, SCR_W + 1));
        // opposite winding, lowest depth
        send_op(tri_op(200, 200, 200, 260, 260, 200, -16384, -16384, -16384, 24'h00ff00));
        send_op(simple_op(OP_READ, 13 * SCR_W + 13));
        // zero area: coincident points, then collinear
        send_op(tri_op(500, 500, 500, 500, 500, 500, 1, 2, 3, 24'h123456));
        send_op(tri_op(100, 100, 132, 132, 164, 164, 1, 2, 3, 24'h123456));
        // clipped at the far corner, then wholly beyond the screen
        send_op(tri_op(2047, 2047, 2007, 2047, 2047, 2007, 100, 200, 300, 24'h0000ff));
        send_op(simple_op(OP_READ, NPIX - 1));
        send_op(tri_op(2040, 100, 2047, 120, 2044, 140, 100, 200, 300, 24'hff0000));
        send_op(tri_op(100, 2040, 120, 2047, 140, 2044, 100, 200, 300, 24'hff0000));
        // one larger triangle with a depth slope, then one crossing it
        send_op(tri_op(600, 600, 920, 620, 700, 900, -16384, 16384, 0, 24'habcdef));
        send_op(tri_op(620, 900, 900, 900, 760, 600, 16384, -16384, 5000, 24'h5a5a5a));
        send_op(simple_op(OP_READ, 45 * SCR_W + 47));
        send_op(tri_op(30, 30, 70, 30, 30, 70, 0, 0, 0, 24'h777777));
        send_op(simple_op(OP_UNUSED, 5));
        send_op(simple_op(OP_READ, 3 * SCR_W + 3));

        for (int p = 0; p < 4; p++) begin
            write_background(bg_values[p]);
            tx_idle_pct = tx_pcts[p];
            rx_stall_pct = rx_pcts[p];
            send_op(simple_op(OP_CLEAR, 0));
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == RANDOM_PER_PHASE / 2) drain();
                send_op(random_op());
            end
        end
        drain();
        repeat (100) @(posedge i_clk);

        $display("covered %0d clears, %0d draws (%0d flat, %0d pixels written), %0d reads",
                 sb.n_clear, sb.n_draw, sb.n_degen, sb.n_pix, sb.n_read);
        $display("four idle/stall phases, %0d mismatches, %0d results left over",
                 sb.mismatches, sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
src/trd_pkg.sv
src/trd_mac.sv
src/trd_div.sv
src/triangle_raster_depth_test.sv
src/trd_checker.sv
test/testbench.sv
